// ===== design/cdq_pkg.sv =====
`default_nettype none

package cdq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int CAP_W         = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam int DATA_W        = 32;
    localparam int REG_CAP       = 0;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    typedef struct packed {
        t_mode                    mode;
        logic signed [DATA_W-1:0] push_value;
    } t_in_word;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] popped_value;
    } t_out_word;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_cmd;

    typedef struct packed {
        logic busy;
        logic empty;
    } t_ctrl_stat;

endpackage

`default_nettype wire

// ===== design/circular_deque_core.sv =====
// Results: a push or a refused pop gives its result word in the cycle after acceptance;
// a pop that succeeds gives it through the RAM read register and then the output register.
// Throughput: one push per cycle unless the output stalls; a successful pop holds the
// input in the ST_READ state while the single memory port returns the slot.
// Reset: synchronous, active low; the deque is empty and the capacity is 16.
// A capacity write also empties the deque.
`default_nettype none

module circular_deque_core #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  cdq_pkg::t_in_word            i_in_word,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output cdq_pkg::t_out_word           o_out_word,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [2:0]                    paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import cdq_pkg::*;

    localparam int IW = $clog2(DEPTH);

    logic [CAP_W-1:0]  r_cap;
    logic              cfg_wr;
    logic              cap_sel;
    t_mem_cmd          mem_cmd;
    logic [IW-1:0]     mem_addr;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] mem_rdata;
    t_ctrl_stat        stat;

    assign pready  = 1'b1;
    assign cap_sel = (paddr[2] == 1'(REG_CAP));
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = cap_sel ? {{(32 - CAP_W){1'b0}}, r_cap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cfg_wr && cap_sel) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    cdq_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap       (r_cap),
        .i_clear     (cfg_wr && cap_sel),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .o_mem_cmd   (mem_cmd),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata),
        .o_stat      (stat)
    );

    cdq_ram #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.busy |=> (o_out_valid && o_out_word.status == STAT_DONE && !stat.busy))
        else $error("pop read did not produce a result word");

    a_cfg_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && cap_sel) |=> stat.empty)
        else $error("capacity write did not empty the deque");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_word.mode[1] && stat.empty) |=>
        (o_out_valid && o_out_word.status == STAT_EMPTY && o_out_word.popped_value == -32'sd1))
        else $error("pop from empty deque was not refused");

    a_no_mem_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_cmd.we && mem_cmd.re))
        else $error("memory read and write issued together");

endmodule

`default_nettype wire

// ===== design/cdq_ram.sv =====
`default_nettype none

module cdq_ram #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
    parameter int IW    = $clog2(DEPTH)
) (
    input  wire                          i_clk,
    input  cdq_pkg::t_mem_cmd            i_cmd,
    input  wire [IW-1:0]                 i_addr,
    input  wire [cdq_pkg::DATA_W-1:0]    i_wdata,
    output logic [cdq_pkg::DATA_W-1:0]   o_rdata
);
    import cdq_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_cmd.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/cdq_ctrl.sv =====
`default_nettype none

module cdq_ctrl #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
    parameter int IW    = $clog2(DEPTH)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire [cdq_pkg::CAP_W-1:0]     i_cap,
    input  wire                          i_clear,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  cdq_pkg::t_in_word            i_in_word,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output cdq_pkg::t_out_word           o_out_word,
    output cdq_pkg::t_mem_cmd            o_mem_cmd,
    output logic [IW-1:0]                o_mem_addr,
    output logic [cdq_pkg::DATA_W-1:0]   o_mem_wdata,
    input  wire [cdq_pkg::DATA_W-1:0]    i_mem_rdata,
    output cdq_pkg::t_ctrl_stat          o_stat
);
    import cdq_pkg::*;

    localparam int CW = ($clog2(DEPTH + 1) > CAP_W) ? $clog2(DEPTH + 1) : CAP_W;

    t_state        r_state, n_state;
    logic [IW-1:0] r_front, n_front;
    logic [IW-1:0] r_back, n_back;
    logic          r_empty, n_empty;
    logic          r_out_vld, n_out_vld;
    t_out_word     r_out, n_out;

    logic [CW-1:0] cap;
    logic [CW-1:0] back_inc_w;
    logic [CW-1:0] front_inc_w;
    logic [IW-1:0] back_inc, front_inc, back_dec, front_dec;
    logic          full;
    logic          in_acc;
    logic          is_pop;
    logic          out_free;

    always_comb begin
        if (i_cap == '0) begin
            cap = CW'(1);
        end else if (CW'(i_cap) > CW'(DEPTH)) begin
            cap = CW'(DEPTH);
        end else begin
            cap = CW'(i_cap);
        end
    end

    assign back_inc_w  = CW'(r_back) + CW'(1);
    assign front_inc_w = CW'(r_front) + CW'(1);
    assign back_inc    = (back_inc_w >= cap) ? '0 : back_inc_w[IW-1:0];
    assign front_inc   = (front_inc_w >= cap) ? '0 : front_inc_w[IW-1:0];
    assign back_dec    = (r_back == '0) ? IW'(cap - CW'(1)) : r_back - IW'(1);
    assign front_dec   = (r_front == '0) ? IW'(cap - CW'(1)) : r_front - IW'(1);
    assign full        = !r_empty && (back_inc == r_front);
    assign is_pop      = i_in_word.mode[1];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && is_pop && !r_empty) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_free   = !r_out_vld || !i_out_stall;
        o_in_stall = (r_state == ST_READ) || !out_free;
        in_acc     = i_in_valid && !o_in_stall;
    end

    always_comb begin
        n_front     = r_front;
        n_back      = r_back;
        n_empty     = r_empty;
        n_out_vld   = r_out_vld && i_out_stall;
        n_out       = r_out;
        o_mem_cmd   = '0;
        o_mem_addr  = r_front;
        o_mem_wdata = i_in_word.push_value;

        if (r_state == ST_READ) begin
            n_out_vld          = 1'b1;
            n_out.status       = STAT_DONE;
            n_out.popped_value = i_mem_rdata;
        end

        if (in_acc) begin
            if (!is_pop) begin
                n_out_vld          = 1'b1;
                n_out.popped_value = '0;
                if (full) begin
                    n_out.status = STAT_FULL;
                end else begin
                    n_out.status = STAT_DONE;
                    o_mem_cmd.we = 1'b1;
                    if (r_empty) begin
                        n_front    = '0;
                        n_back     = '0;
                        n_empty    = 1'b0;
                        o_mem_addr = '0;
                    end else if (i_in_word.mode == MODE_PUSH_FRONT) begin
                        n_front    = front_dec;
                        o_mem_addr = front_dec;
                    end else begin
                        n_back     = back_inc;
                        o_mem_addr = back_inc;
                    end
                end
            end else if (r_empty) begin
                n_out_vld          = 1'b1;
                n_out.status       = STAT_EMPTY;
                n_out.popped_value = '1;
            end else begin
                o_mem_cmd.re = 1'b1;
                o_mem_addr   = (i_in_word.mode == MODE_POP_FRONT) ? r_front : r_back;
                if (r_front == r_back) begin
                    n_front = '0;
                    n_back  = '0;
                    n_empty = 1'b1;
                end else if (i_in_word.mode == MODE_POP_FRONT) begin
                    n_front = front_inc;
                end else begin
                    n_back = back_dec;
                end
            end
        end

        if (i_clear) begin
            n_front = '0;
            n_back  = '0;
            n_empty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_front   <= '0;
            r_back    <= '0;
            r_empty   <= 1'b1;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_front   <= n_front;
            r_back    <= n_back;
            r_empty   <= n_empty;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid  = r_out_vld;
    assign o_out_word   = r_out;
    assign o_stat.busy  = (r_state == ST_READ);
    assign o_stat.empty = r_empty;

endmodule

`default_nettype wire

// ===== bench/deque_checker.sv =====
`default_nettype none

module deque_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_stall,
    input  cdq_pkg::t_in_word   i_in_word,
    input  wire                 i_out_valid,
    input  wire                 i_out_stall,
    input  cdq_pkg::t_out_word  i_out_word,
    input  wire                 i_psel,
    input  wire                 i_penable,
    input  wire                 i_pwrite,
    input  wire                 i_pready,
    input  wire [2:0]           i_paddr,
    input  wire [31:0]          i_pwdata,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);
    import cdq_pkg::*;

    localparam logic [2:0] CAP_ADDR = 3'(REG_CAP * 4);
    localparam int SLOTS = DEPTH_DEFAULT;

    logic [DATA_W-1:0] slot_copy [SLOTS];
    logic [3:0]        head_idx;
    logic [3:0]        tail_idx;
    logic              deque_empty;
    logic [CAP_W-1:0]  cap_reg;
    t_out_word         expected_words [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic logic [3:0] step_up(input logic [3:0] idx, input logic [4:0] lim);
        return ({1'b0, idx} + 5'd1 >= lim) ? 4'd0 : idx + 4'd1;
    endfunction

    function automatic logic [3:0] step_down(input logic [3:0] idx, input logic [4:0] lim);
        return (idx == 4'd0) ? 4'(lim - 5'd1) : idx - 4'd1;
    endfunction

    task automatic clear_deque();
        head_idx    = 4'd0;
        tail_idx    = 4'd0;
        deque_empty = 1'b1;
    endtask

    task automatic apply_op(input t_in_word w, output t_out_word r);
        logic [4:0] lim;
        logic [3:0] slot;
        logic       full;
        lim = cap_reg;
        if (lim == 5'd0) lim = 5'd1;
        if (lim > 5'(SLOTS)) lim = 5'(SLOTS);
        if ({1'b0, head_idx} >= lim) head_idx = 4'd0;
        if ({1'b0, tail_idx} >= lim) tail_idx = 4'd0;
        full = !deque_empty && (step_up(tail_idx, lim) == head_idx);
        r.status       = STAT_DONE;
        r.popped_value = '0;
        if (w.mode == MODE_PUSH_FRONT || w.mode == MODE_PUSH_BACK) begin
            if (full) begin
                r.status = STAT_FULL;
            end else begin
                if (deque_empty) begin
                    clear_deque();
                    deque_empty = 1'b0;
                    slot = 4'd0;
                end else if (w.mode == MODE_PUSH_FRONT) begin
                    head_idx = step_down(head_idx, lim);
                    slot = head_idx;
                end else begin
                    tail_idx = step_up(tail_idx, lim);
                    slot = tail_idx;
                end
                slot_copy[slot] = w.push_value;
            end
        end else if (deque_empty) begin
            r.status       = STAT_EMPTY;
            r.popped_value = '1;
        end else begin
            slot = (w.mode == MODE_POP_FRONT) ? head_idx : tail_idx;
            r.popped_value = slot_copy[slot];
            if (head_idx == tail_idx) begin
                clear_deque();
            end else if (w.mode == MODE_POP_FRONT) begin
                head_idx = step_up(head_idx, lim);
            end else begin
                tail_idx = step_down(tail_idx, lim);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_word want;
        t_out_word got;
        if (!i_rst_n) begin
            cap_reg = CAP_RESET;
            clear_deque();
            expected_words.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == CAP_ADDR) begin
                cap_reg = i_pwdata[CAP_W-1:0];
                clear_deque();
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_word;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got status %0d value %0d",
                             $time, got.status, $signed(got.popped_value));
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    o_checked++;
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d got %0d",
                                 $time, want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.popped_value !== want.popped_value) begin
                        $display("%0t: popped value mismatch, expected %0d got %0d",
                                 $time, $signed(want.popped_value), $signed(got.popped_value));
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_op(i_in_word, want);
                expected_words.push_back(want);
            end
        end
        o_pending = expected_words.size();
    end

endmodule

`default_nettype wire

// ===== bench/tb_circular_deque_core.sv =====
`default_nettype none

module tb_circular_deque_core;
    import cdq_pkg::*;

    localparam logic [2:0] CAP_ADDR   = 3'(REG_CAP * 4);
    localparam int         SEG_WORDS  = 192;
    localparam longint     LIMIT_TIME = 4_000_000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_word    in_word;
    logic        out_valid;
    logic        out_stall;
    t_out_word   out_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked;
    int send_gap_pct;
    int recv_stall_pct;
    int words_sent;
    int cap_writes;

    logic [4:0] seg_caps [6] = '{5'd5, 5'd31, 5'd1, 5'd16, 5'd17, 5'd9};

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    circular_deque_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    deque_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always @(negedge clk) begin
        out_stall = ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        #(LIMIT_TIME);
        $display("tb_circular_deque_core failed");
        $finish;
    end

    task automatic send_word(input t_mode m, input logic [31:0] v);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid        = 1'b1;
        in_word.mode    = m;
        in_word.push_value = v;
        do @(posedge clk); while (in_stall);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic write_capacity(input logic [4:0] value);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = CAP_ADDR;
        pwdata  = {27'd0, value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        cap_writes++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(15))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_mode pick_mode(input int lean);
        int  roll;
        logic push;
        logic back;
        roll = $urandom_range(99);
        push = (lean == 0) ? (roll < 75) : (lean == 1) ? (roll < 25) : (roll < 50);
        back = 1'($urandom_range(1));
        if (push) return back ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        return back ? MODE_POP_BACK : MODE_POP_FRONT;
    endfunction

    initial begin
        int n;
        int burst;
        int lean;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_word        = '0;
        out_stall      = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_gap_pct   = 21;
        recv_stall_pct = 54;
        words_sent     = 0;
        cap_writes     = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        send_word(MODE_POP_FRONT, 32'h1234_5678);
        send_word(MODE_POP_BACK, 32'hFFFF_FFFF);
        send_word(MODE_PUSH_FRONT, 32'h7FFF_FFFF);
        send_word(MODE_PUSH_BACK, 32'h8000_0000);
        send_word(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
        send_word(MODE_PUSH_BACK, 32'h0000_0000);
        send_word(MODE_POP_FRONT, 32'h0);
        send_word(MODE_POP_BACK, 32'h0);
        send_word(MODE_POP_FRONT, 32'h0);
        send_word(MODE_POP_BACK, 32'h0);
        send_word(MODE_POP_FRONT, 32'h0);

        write_capacity(5'd2);
        send_word(MODE_PUSH_BACK, 32'h0000_0001);
        send_word(MODE_PUSH_FRONT, 32'h0000_0002);
        send_word(MODE_PUSH_BACK, 32'h0000_0003);
        send_word(MODE_PUSH_FRONT, 32'h0000_0004);
        send_word(MODE_POP_BACK, 32'h0);
        send_word(MODE_POP_BACK, 32'h0);
        send_word(MODE_POP_BACK, 32'h0);

        write_capacity(5'd0);
        send_word(MODE_PUSH_FRONT, 32'h5555_AAAA);
        send_word(MODE_PUSH_BACK, 32'hAAAA_5555);
        send_word(MODE_POP_FRONT, 32'h0);
        send_word(MODE_POP_BACK, 32'h0);

        for (int seg = 0; seg < 6; seg++) begin
            if (seg == 2) begin
                send_gap_pct   = 54;
                recv_stall_pct = 21;
            end else if (seg == 4) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            write_capacity(seg_caps[seg]);
            n = 0;
            while (n < SEG_WORDS) begin
                burst = $urandom_range(4, 40);
                lean  = $urandom_range(2);
                for (int k = 0; k < burst && n < SEG_WORDS; k++) begin
                    send_word(pick_mode(lean), pick_value());
                    n++;
                end
            end
        end
        in_valid = 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Sent %0d words over %0d capacity settings, including 0, 1, 16 and 31.",
                 words_sent, cap_writes + 1);
        $display("Compared %0d result words against the predicted deque contents.", checked);
        if (fail_count == 0) begin
            $display("tb_circular_deque_core passed");
        end else begin
            $display("tb_circular_deque_core failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/cdq_pkg.sv
design/cdq_ram.sv
design/cdq_ctrl.sv
design/circular_deque_core.sv
bench/deque_checker.sv
bench/tb_circular_deque_core.sv
